/* rtl/mde_pkg.sv */
`default_nettype none
package mde_pkg;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NOT_SQUARE = 2'd1;
	localparam logic [1:0] STATUS_SATURATED  = 2'd2;

	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;
	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// A Q32.32 value together with a flag telling whether it was clipped.
	typedef struct packed {
		logic        sat;
		logic [63:0] val;
	} qres_t;

	function automatic logic [63:0] q_mag(input logic [63:0] x);
		q_mag = x[63] ? (64'd0 - x) : x;
	endfunction

	// Applies a sign to a magnitude, clipping to the Q32.32 range.
	function automatic qres_t q_pack(input logic neg, input logic over, input logic [63:0] m);
		qres_t r;
		r.sat = 1'b0;
		if (neg) begin
			if (over || m > Q_MIN) begin
				r.sat = 1'b1;
				r.val = Q_MIN;
			end else begin
				r.val = 64'd0 - m;
			end
		end else begin
			if (over || m >= Q_MIN) begin
				r.sat = 1'b1;
				r.val = Q_MAX;
			end else begin
				r.val = m;
			end
		end
		return r;
	endfunction

	function automatic qres_t q_sub(input logic [63:0] a, input logic [63:0] b);
		qres_t       r;
		logic [63:0] d;
		d = a - b;
		r.sat = 1'b0;
		r.val = d;
		if ((a[63] ^ b[63]) && (a[63] ^ d[63])) begin
			r.sat = 1'b1;
			r.val = a[63] ? Q_MIN : Q_MAX;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/matrix_determinant_elimination.sv */
`default_nettype none
// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------
// input    | in_valid / in_ready    | element_value (Q16.16), is_final
// output   | out_valid / out_ready  | det_value (Q32.32), status
// config   | psel/penable/pwrite    | paddr, pwdata, prdata (row/column count)
//
// Elements load at one item per cycle into the matrix memory. The item marked
// final starts the elimination, during which in_ready is low. Every step goes
// through the matrix memory (one read and one write port) and the shared
// arithmetic: a multiply forms four 32x32 partial products, a division yields
// one quotient bit a cycle. The result waits in an output register, and
// a new matrix may load while it is still waiting. Reset clears control state
// only; the matrix memory holds nothing meaningful until written.
module matrix_determinant_elimination #(
	parameter int MAX_DIM = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] element_value,
	input  wire logic        is_final,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic [63:0]      det_value,
	output logic [1:0]       status,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int LW    = $clog2(CELLS + 1);
	localparam int DW    = $clog2(MAX_DIM + 1);

	// One-hot sequencer states. The names follow the loops of the elimination:
	// pivot fetch, pivot search, row swap, row reduction and the diagonal product.
	typedef enum logic [23:0] {
		S_LOAD     = 24'h000001,
		S_PIV_RD   = 24'h000002,
		S_PIV_CHK  = 24'h000004,
		S_SRCH_RD  = 24'h000008,
		S_SRCH_CHK = 24'h000010,
		S_SW_RDA   = 24'h000020,
		S_SW_RDB   = 24'h000040,
		S_SW_WRA   = 24'h000080,
		S_SW_WRB   = 24'h000100,
		S_NEXT_COL = 24'h000200,
		S_ROW_RD   = 24'h000400,
		S_ROW_CHK  = 24'h000800,
		S_DIV      = 24'h001000,
		S_DIV_END  = 24'h002000,
		S_UPD_RD   = 24'h004000,
		S_UPD_MUL  = 24'h008000,
		S_MUL      = 24'h010000,
		S_MUL_END  = 24'h020000,
		S_UPD_RD2  = 24'h040000,
		S_UPD_WR   = 24'h080000,
		S_DET_RD   = 24'h100000,
		S_DET_MUL  = 24'h200000,
		S_SIGN     = 24'h400000,
		S_DONE     = 24'h800000
	} state_t;

	state_t         state_q;
	logic [3:0]     row_q, col_q;
	logic [LW-1:0]  load_q;
	logic [DW-1:0]  n_q, i_q, j_q, k_q;
	logic           nsq_q, sat_q, swap_q, det_mode_q;
	logic [63:0]    piv_q, tmp_q, g_q, prod_q, acc_q;
	logic [63:0]    opa_q, opb_q;
	logic           neg_q;
	logic [6:0]     cnt_q;
	logic [63:0]    pp_q;
	logic [127:0]   mac_q;
	logic [63:0]    rem_q;
	logic [95:0]    quo_q;

	logic [63:0]    mem [CELLS];
	logic [63:0]    rd_q;
	logic [AW-1:0]  raddr, waddr;
	logic [63:0]    wdata;
	logic           we;

	logic           in_acc, cfg_wr, out_free;
	logic [3:0]     n_raw;
	logic [DW-1:0]  n_clamp;
	mde_pkg::qres_t mul_res, div_res, sub_res, neg_res;
	logic [64:0]    div_t;
	logic           div_bit;
	logic [127:0]   mac_add;

	function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] r,
			input logic [DW-1:0] c, input logic [DW-1:0] n);
		logic [2*DW-1:0] p;
		p = r * n;
		p = p + {{DW{1'b0}}, c};
		return p[AW-1:0];
	endfunction

	assign in_ready = (state_q == S_LOAD);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = {28'd0, (paddr[2] == mde_pkg::REG_COLUMN_COUNT) ? col_q : row_q};

	// Sizes of zero count as one and sizes beyond the memory are cut down to it.
	always_comb begin
		n_raw = row_q;
		if (n_raw == 4'd0) begin
			n_raw = 4'd1;
		end
		if (32'(n_raw) > MAX_DIM) begin
			n_clamp = DW'(MAX_DIM);
		end else begin
			n_clamp = DW'(n_raw);
		end
	end

	// Shared arithmetic: result packing of the multiplier and the divider, the
	// saturating subtraction, the sign flip, one restoring division step and the partial product accumulation.
	always_comb begin
		mul_res = mde_pkg::q_pack(neg_q, mac_q[127:96] != 32'd0, mac_q[95:32]);
		div_res = mde_pkg::q_pack(neg_q, quo_q[95:64] != 32'd0, quo_q[63:0]);
		sub_res = mde_pkg::q_sub(rd_q, prod_q);
		neg_res = mde_pkg::q_pack(!acc_q[63], 1'b0, mde_pkg::q_mag(acc_q));
		div_t   = {rem_q, quo_q[95]};
		div_bit = (div_t >= {1'b0, opb_q});
		case (cnt_q[2:0])
			3'd1:    mac_add = {64'd0, pp_q};
			3'd2:    mac_add = {32'd0, pp_q, 32'd0};
			3'd3:    mac_add = {32'd0, pp_q, 32'd0};
			3'd4:    mac_add = {pp_q, 64'd0};
			default: mac_add = 128'd0;
		endcase
	end

	// Memory addressing for each sequencer step.
	always_comb begin
		raddr = cell_addr(i_q, i_q, n_q);
		we    = 1'b0;
		waddr = load_q[AW-1:0];
		wdata = {{16{element_value[31]}}, element_value, 16'd0};
		case (state_q)
			S_LOAD: begin
				we = in_acc && (load_q < LW'(CELLS));
			end
			S_SRCH_RD, S_ROW_RD: raddr = cell_addr(k_q, i_q, n_q);
			S_SW_RDA, S_UPD_RD:  raddr = cell_addr(i_q, j_q, n_q);
			S_SW_RDB, S_UPD_RD2: raddr = cell_addr(k_q, j_q, n_q);
			S_SW_WRA: begin
				we    = 1'b1;
				waddr = cell_addr(i_q, j_q, n_q);
				wdata = rd_q;
			end
			S_SW_WRB: begin
				we    = 1'b1;
				waddr = cell_addr(k_q, j_q, n_q);
				wdata = tmp_q;
			end
			S_UPD_WR: begin
				we    = 1'b1;
				waddr = cell_addr(k_q, j_q, n_q);
				wdata = sub_res.val;
			end
			default: begin
			end
		endcase
		// The cleared entry below the pivot is written once its row is done.
		if (state_q == S_UPD_RD && j_q >= n_q) begin
			we    = 1'b1;
			waddr = cell_addr(k_q, i_q, n_q);
			wdata = 64'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 4'd8;
			col_q <= 4'd8;
		end else if (cfg_wr) begin
			if (paddr[2] == mde_pkg::REG_ROW_COUNT) begin
				row_q <= pwdata[3:0];
			end else begin
				col_q <= pwdata[3:0];
			end
		end
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			load_q     <= '0;
			out_valid  <= 1'b0;
			nsq_q      <= 1'b0;
			sat_q      <= 1'b0;
			swap_q     <= 1'b0;
			det_mode_q <= 1'b0;
			cnt_q      <= '0;
			n_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (is_final) begin
							load_q <= '0;
							swap_q <= 1'b0;
							sat_q  <= 1'b0;
							nsq_q  <= (row_q != col_q);
							n_q    <= n_clamp;
							i_q    <= '0;
							state_q <= (row_q != col_q) ? S_DONE : S_PIV_RD;
						end else if (load_q < LW'(CELLS)) begin
							load_q <= load_q + LW'(1);
						end
					end
				end
				S_PIV_RD: state_q <= S_PIV_CHK;
				S_PIV_CHK: begin
					piv_q <= rd_q;
					k_q   <= i_q + DW'(1);
					state_q <= (rd_q != 64'd0) ? S_ROW_RD : S_SRCH_RD;
				end
				S_SRCH_RD: begin
					state_q <= (k_q >= n_q) ? S_NEXT_COL : S_SRCH_CHK;
				end
				S_SRCH_CHK: begin
					if (rd_q != 64'd0) begin
						piv_q   <= rd_q;
						j_q     <= '0;
						state_q <= S_SW_RDA;
					end else begin
						k_q     <= k_q + DW'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_SW_RDA: state_q <= S_SW_RDB;
				S_SW_RDB: begin
					tmp_q   <= rd_q;
					state_q <= S_SW_WRA;
				end
				S_SW_WRA: state_q <= S_SW_WRB;
				S_SW_WRB: begin
					if (j_q + DW'(1) >= n_q) begin
						swap_q  <= !swap_q;
						k_q     <= i_q + DW'(1);
						state_q <= S_ROW_RD;
					end else begin
						j_q     <= j_q + DW'(1);
						state_q <= S_SW_RDA;
					end
				end
				S_NEXT_COL: begin
					if (i_q + DW'(1) >= n_q) begin
						i_q     <= '0;
						acc_q   <= mde_pkg::Q_ONE;
						state_q <= S_DET_RD;
					end else begin
						i_q     <= i_q + DW'(1);
						state_q <= S_PIV_RD;
					end
				end
				S_ROW_RD: begin
					state_q <= (k_q >= n_q) ? S_NEXT_COL : S_ROW_CHK;
				end
				S_ROW_CHK: begin
					if (rd_q == 64'd0) begin
						k_q     <= k_q + DW'(1);
						state_q <= S_ROW_RD;
					end else begin
						neg_q   <= rd_q[63] ^ piv_q[63];
						opb_q   <= mde_pkg::q_mag(piv_q);
						quo_q   <= {mde_pkg::q_mag(rd_q), 32'd0};
						rem_q   <= 64'd0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= div_bit ? 64'(div_t - {1'b0, opb_q}) : div_t[63:0];
					quo_q <= {quo_q[94:0], div_bit};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd95) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					sat_q <= sat_q | div_res.sat;
					g_q   <= div_res.val;
					if (div_res.val == 64'd0) begin
						k_q     <= k_q + DW'(1);
						state_q <= S_ROW_RD;
					end else begin
						j_q     <= i_q + DW'(1);
						state_q <= S_UPD_RD;
					end
				end
				S_UPD_RD: begin
					if (j_q >= n_q) begin
						k_q     <= k_q + DW'(1);
						state_q <= S_ROW_RD;
					end else begin
						state_q <= S_UPD_MUL;
					end
				end
				S_UPD_MUL: begin
					opa_q      <= mde_pkg::q_mag(g_q);
					opb_q      <= mde_pkg::q_mag(rd_q);
					neg_q      <= g_q[63] ^ rd_q[63];
					det_mode_q <= 1'b0;
					cnt_q      <= '0;
					state_q    <= S_MUL;
				end
				S_MUL: begin
					// Partial products a0b0, a0b1, a1b0, a1b1, each registered in pp_q and then added to mac_q.
					pp_q  <= (cnt_q[1] ? opa_q[63:32] : opa_q[31:0]) *
						(cnt_q[0] ? opb_q[63:32] : opb_q[31:0]);
					mac_q <= (cnt_q == 7'd0) ? 128'd0 : mac_q + mac_add;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd4) begin
						state_q <= S_MUL_END;
					end
				end
				S_MUL_END: begin
					sat_q <= sat_q | mul_res.sat;
					if (det_mode_q) begin
						acc_q   <= mul_res.val;
						i_q     <= i_q + DW'(1);
						state_q <= S_DET_RD;
					end else begin
						prod_q  <= mul_res.val;
						state_q <= S_UPD_RD2;
					end
				end
				S_UPD_RD2: state_q <= S_UPD_WR;
				S_UPD_WR: begin
					sat_q   <= sat_q | sub_res.sat;
					j_q     <= j_q + DW'(1);
					state_q <= S_UPD_RD;
				end
				S_DET_RD: begin
					state_q <= (i_q >= n_q) ? S_SIGN : S_DET_MUL;
				end
				S_DET_MUL: begin
					opa_q      <= mde_pkg::q_mag(acc_q);
					opb_q      <= mde_pkg::q_mag(rd_q);
					neg_q      <= acc_q[63] ^ rd_q[63];
					det_mode_q <= 1'b1;
					cnt_q      <= '0;
					state_q    <= S_MUL;
				end
				S_SIGN: begin
					if (swap_q) begin
						acc_q <= neg_res.val;
						sat_q <= sat_q | neg_res.sat;
					end
					swap_q  <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						det_value <= nsq_q ? 64'd0 : acc_q;
						status    <= nsq_q ? mde_pkg::STATUS_NOT_SQUARE :
							(sat_q ? mde_pkg::STATUS_SATURATED : mde_pkg::STATUS_OK);
						state_q   <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/mde_chk.sv */
`default_nettype none
module mde_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        is_final,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] det_value,
	input wire logic [1:0]  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(det_value) && $stable(status))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == mde_pkg::STATUS_OK || status == mde_pkg::STATUS_NOT_SQUARE
			|| status == mde_pkg::STATUS_SATURATED)
		else $error("status code out of range");

	a_nsq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mde_pkg::STATUS_NOT_SQUARE |-> det_value == 64'd0)
		else $error("non-square result is not zero");

	a_busy_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_final |=> !in_ready)
		else $error("input taken right after the final item");

endmodule

bind matrix_determinant_elimination mde_chk u_mde_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.is_final  (is_final),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.det_value (det_value),
	.status    (status)
);
`default_nettype wire
